FILE: design/ssh_binary_packet_framer_core_assert.svh
// ----------------------------------------------------------------------------
// SSH packet framer assertion macros
// Shared concurrent assertion forms, clocked on clk, idle during reset.
// ----------------------------------------------------------------------------
`ifndef SSH_BINARY_PACKET_FRAMER_CORE_ASSERT_SVH
`define SSH_BINARY_PACKET_FRAMER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SBPF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SBPF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ssh_bpf_pkg.sv
// ----------------------------------------------------------------------------
// ssh_bpf_pkg
// Types, constants and controller/datapath interface for the packet framer.
// ----------------------------------------------------------------------------
package ssh_bpf_pkg;

	localparam logic [15:0] MAX_PAYLOAD = 16'd32768;
	localparam logic [5:0]  BS_MIN      = 6'd4;
	localparam logic [5:0]  BS_MAX      = 6'd32;
	localparam logic [5:0]  PAD_MIN     = 6'd4;
	localparam logic [15:0] HDR_OVERHEAD = 16'd5;   // 4 length bytes + pad length
	localparam logic [31:0] LFSR_TAPS   = 32'h8020_0003;

	// configuration register indexes
	localparam logic CFG_BLOCK_SIZE = 1'b0;
	localparam logic CFG_SEED       = 1'b1;

	// header byte positions carrying the nonzero part of the packet length
	localparam logic [1:0] HDR_IDX_HI = 2'd2;
	localparam logic [1:0] HDR_IDX_LO = 2'd3;

	typedef enum logic [1:0] {
		KIND_LEN    = 2'd0,
		KIND_PADLEN = 2'd1,
		KIND_PAY    = 2'd2,
		KIND_PAD    = 2'd3
	} kind_t;

	typedef struct packed {
		logic       accept;    // input transfer this cycle
		logic       div_step;  // one remainder step
		logic       calc;      // form pad count and packet length
		logic       emit;      // load output register
		kind_t      kind;
		logic [1:0] hdr_idx;
		logic       eop;
	} cmd_t;

	typedef struct packed {
		logic bl_zero;   // next input starts a packet
		logic bl_one;    // payload byte in hand is the last
		logic pad_last;  // one padding byte left
		logic out_free;  // output register can load
	} sts_t;

endpackage

FILE: design/ssh_binary_packet_framer_core.sv
// ----------------------------------------------------------------------------
// ssh_binary_packet_framer_core
// Frames payload bytes into SSH binary packets: length, pad length, payload,
// random padding aligned to the cipher block size.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                        | tuser        | tlast
//  s_*     | in  | [7:0] payload_byte,          | -            | -
//          |     | [23:8] payload_length        |              |
//  m_*     | out | [7:0] out_byte               | [1:0] kind   | end_of_packet
//  cfg_*   | in  | cfg_addr 0 block_size, 1 padding_seed, data cfg_data[31:0]
//
// Payload bytes inside a packet go in at one per cycle while the output
// register is free. The first byte of a packet passes through accept, the
// bit-serial remainder unit ((5 + length) mod block size, one quotient bit a
// cycle), a step forming pad and length, five header bytes and the payload
// byte. The packet tail then adds the padding bytes, 4 to 35 of them.
// Reset: arst_n clears the sequencer, counters, block size (8) and LFSR (1).
// Stalls: a single output register sits between controller and m_*; the
// sequencer waits on it, and input is taken only in idle or straight behind
// a non-final payload byte.
// ----------------------------------------------------------------------------
module ssh_binary_packet_framer_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [31:0] cfg_data,
	// payload in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // [7:0] payload_byte, [23:8] payload_length
	// framed bytes out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] out_byte
	output logic [1:0]  m_tuser,    // [1:0] byte_kind
	output logic        m_tlast     // end_of_packet
);

	ssh_bpf_pkg::cmd_t cmd;
	ssh_bpf_pkg::sts_t sts;

	// sequencer: one transfer step per state, commands only
	ssh_bpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: registers, remainder unit, LFSR and output register
	ssh_bpf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: design/ssh_bpf_dp.sv
// ----------------------------------------------------------------------------
// ssh_bpf_dp
// Framer datapath: config, bit-serial remainder, counters, LFSR, output reg.
// ----------------------------------------------------------------------------
module ssh_bpf_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_addr,
	input  logic [31:0]       cfg_data,
	input  logic [23:0]       s_tdata,
	input  ssh_bpf_pkg::cmd_t cmd,
	output ssh_bpf_pkg::sts_t sts,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [7:0]        m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	logic [5:0]  block_size_q;
	logic [15:0] bytes_left_q;
	logic [5:0]  pad_cnt_q;
	logic [31:0] lfsr_q;
	logic        m_tvalid_q;

	logic [7:0]  byte_q;
	logic [5:0]  bs_q;
	logic [15:0] dvd_q;
	logic [5:0]  rem_q;
	logic [15:0] plen_q;
	logic [7:0]  m_tdata_q;
	logic [1:0]  m_tuser_q;
	logic        m_tlast_q;

	logic [15:0] in_len;
	logic [15:0] len_clamp;
	logic [5:0]  bs_clamp;
	logic [5:0]  rem_sh;
	logic [5:0]  pad_base;
	logic [5:0]  pad_fix;
	logic [31:0] lfsr_nxt;
	logic [7:0]  out_byte;

	assign in_len = s_tdata[23:8];

	always_comb begin
		if (in_len == 16'd0) begin
			len_clamp = 16'd1;
		end else if (in_len > ssh_bpf_pkg::MAX_PAYLOAD) begin
			len_clamp = ssh_bpf_pkg::MAX_PAYLOAD;
		end else begin
			len_clamp = in_len;
		end
		if (block_size_q < ssh_bpf_pkg::BS_MIN) begin
			bs_clamp = ssh_bpf_pkg::BS_MIN;
		end else if (block_size_q > ssh_bpf_pkg::BS_MAX) begin
			bs_clamp = ssh_bpf_pkg::BS_MAX;
		end else begin
			bs_clamp = block_size_q;
		end
	end

	// remainder stays below bs (<= 32), so rem_q[5] is clear before the shift
	assign rem_sh   = {rem_q[4:0], dvd_q[15]};
	assign pad_base = bs_q - rem_q;
	assign pad_fix  = (pad_base < ssh_bpf_pkg::PAD_MIN) ? (pad_base + bs_q) : pad_base;
	assign lfsr_nxt = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? ssh_bpf_pkg::LFSR_TAPS : 32'd0);

	always_comb begin
		case (cmd.kind)
			ssh_bpf_pkg::KIND_LEN: begin
				if (cmd.hdr_idx == ssh_bpf_pkg::HDR_IDX_HI) begin
					out_byte = plen_q[15:8];
				end else if (cmd.hdr_idx == ssh_bpf_pkg::HDR_IDX_LO) begin
					out_byte = plen_q[7:0];
				end else begin
					out_byte = 8'd0;
				end
			end
			ssh_bpf_pkg::KIND_PADLEN: out_byte = {2'b00, pad_cnt_q};
			ssh_bpf_pkg::KIND_PAY:    out_byte = byte_q;
			ssh_bpf_pkg::KIND_PAD:    out_byte = lfsr_nxt[7:0];
			default:                  out_byte = 8'd0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= 6'd8;
			bytes_left_q <= 16'd0;
			pad_cnt_q    <= 6'd0;
			lfsr_q       <= 32'd1;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					ssh_bpf_pkg::CFG_BLOCK_SIZE: block_size_q <= cfg_data[5:0];
					ssh_bpf_pkg::CFG_SEED:
						lfsr_q <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept && sts.bl_zero) begin
				bytes_left_q <= len_clamp;
			end
			if (cmd.calc) begin
				pad_cnt_q <= pad_fix;
			end
			if (cmd.emit && cmd.kind == ssh_bpf_pkg::KIND_PAY) begin
				bytes_left_q <= bytes_left_q - 16'd1;
			end
			if (cmd.emit && cmd.kind == ssh_bpf_pkg::KIND_PAD) begin
				pad_cnt_q <= pad_cnt_q - 6'd1;
				lfsr_q    <= lfsr_nxt;
			end
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= s_tdata[7:0];
		end
		if (cmd.accept && sts.bl_zero) begin
			bs_q  <= bs_clamp;
			dvd_q <= len_clamp + ssh_bpf_pkg::HDR_OVERHEAD;
			rem_q <= 6'd0;
		end
		if (cmd.div_step) begin
			rem_q <= (rem_sh >= bs_q) ? (rem_sh - bs_q) : rem_sh;
			dvd_q <= {dvd_q[14:0], 1'b0};
		end
		if (cmd.calc) begin
			plen_q <= bytes_left_q + {10'd0, pad_fix} + 16'd1;
		end
		if (cmd.emit) begin
			m_tdata_q <= out_byte;
			m_tuser_q <= cmd.kind;
			m_tlast_q <= cmd.eop;
		end
	end

	assign sts.bl_zero  = (bytes_left_q == 16'd0);
	assign sts.bl_one   = (bytes_left_q == 16'd1);
	assign sts.pad_last = (pad_cnt_q == 6'd1);
	assign sts.out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`include "ssh_binary_packet_framer_core_assert.svh"

	`SBPF_ASSERT_NXT(a_pad_range, cmd.calc, (pad_cnt_q >= 6'd4) && (pad_cnt_q <= 6'd35), "pad count out of range")
	`SBPF_ASSERT_IMP(a_rem_below_bs, cmd.div_step, rem_q < bs_q, "remainder not below block size")
	`SBPF_ASSERT_IMP(a_lfsr_live, cmd.emit && cmd.kind == ssh_bpf_pkg::KIND_PAD, lfsr_q != 32'd0, "padding LFSR locked at zero")

endmodule

FILE: design/ssh_bpf_ctrl.sv
// ----------------------------------------------------------------------------
// ssh_bpf_ctrl
// Framer controller: sequences accept, remainder, header, payload, padding.
// ----------------------------------------------------------------------------
module ssh_bpf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  ssh_bpf_pkg::sts_t sts,
	output ssh_bpf_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_CALC = 6'b000100,
		ST_HDR  = 6'b001000,
		ST_PAY  = 6'b010000,
		ST_PAD  = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] step_q, step_d;

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		s_tready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.div_step = 1'b0;
		cmd.calc     = 1'b0;
		cmd.emit     = 1'b0;
		cmd.kind     = ssh_bpf_pkg::KIND_PAY;
		cmd.hdr_idx  = step_q[1:0];
		cmd.eop      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					step_d     = 4'd0;
					state_d    = sts.bl_zero ? ST_DIV : ST_PAY;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 4'd1;
				if (&step_q) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				step_d   = 4'd0;
				state_d  = ST_HDR;
			end
			ST_HDR: begin
				cmd.kind = (step_q == 4'd4) ? ssh_bpf_pkg::KIND_PADLEN : ssh_bpf_pkg::KIND_LEN;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					step_d   = step_q + 4'd1;
					if (step_q == 4'd4) begin
						state_d = ST_PAY;
					end
				end
			end
			ST_PAY: begin
				cmd.kind = ssh_bpf_pkg::KIND_PAY;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.bl_one) begin
						state_d = ST_PAD;
					end else begin
						// next byte of the same packet can ride in right behind
						s_tready = 1'b1;
						if (s_tvalid) begin
							cmd.accept = 1'b1;
						end else begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_PAD: begin
				cmd.kind = ssh_bpf_pkg::KIND_PAD;
				cmd.eop  = sts.pad_last;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.pad_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= 4'd0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	`include "ssh_binary_packet_framer_core_assert.svh"

	`SBPF_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free, "output loaded while occupied")
	`SBPF_ASSERT_NXT(a_div_to_calc, state_q == ST_DIV && (&step_q), state_q == ST_CALC, "remainder did not finish after 16 steps")
	`SBPF_ASSERT_NXT(a_eop_idle, cmd.emit && cmd.eop, state_q == ST_IDLE, "end of packet without return to idle")

endmodule

FILE: sim/ssh_binary_packet_framer_core_tb.sv
// ----------------------------------------------------------------------------
// ssh_binary_packet_framer_core_tb
// Self-checking bench for the SSH packet framer. All packets but the last
// go in whole. The bench keeps its own framer state and queues every framed
// byte it expects: length field, pad length, payload and LFSR padding. Each
// output transfer is checked against the oldest queued byte. A short packet
// table covers reset values, block-size clamping, zero length and seed and the
// largest padding. Random packets follow, with random config changes between
// them, random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module ssh_binary_packet_framer_core_tb;

	localparam int unsigned CYCLE_LIMIT  = 500_000;
	localparam int          RANDOM_ITEMS = 110;
	localparam int          HOLD_CYCLES  = 200;  // long output back-pressure
	localparam int          SETTLE       = 8;    // quiet cycles before a config write
	localparam int          TAIL_CYCLES  = 64;   // watch for stray output at the end
	localparam int          MAX_REPORTS  = 10;
	localparam logic [5:0]  BS_RESET     = 6'd8;
	localparam logic [31:0] SEED_RESET   = 32'd1;

	// one framed output byte as the sink should see it
	typedef struct packed {
		logic [7:0]         data;
		ssh_bpf_pkg::kind_t kind;
		logic               last;
	} frame_byte_t;

	// one row of the directed packet table
	typedef struct packed {
		logic        set_bs;
		logic [31:0] bs_val;
		logic        set_seed;
		logic [31:0] seed_val;
		logic [15:0] len_field;  // as driven on the first byte
		logic [15:0] n_bytes;    // payload bytes actually sent
		logic        mid_write;  // block size write after the first byte
		logic [31:0] mid_bs;
		logic [7:0]  exp_pad;    // typed-in pad length, 0: not typed
		logic [31:0] exp_plen;
	} pkt_step_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_addr;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;    // [7:0] payload_byte, [23:8] payload_length
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;    // [7:0] out_byte
	logic [1:0]  m_tuser;    // [1:0] byte_kind
	logic        m_tlast;

	// framer state mirrored by the bench
	logic [5:0]  fr_block_size;
	logic [15:0] fr_bytes_left;
	logic [5:0]  fr_pad_count;
	logic [31:0] fr_lfsr;
	int unsigned fr_last_pad;
	int unsigned fr_last_plen;

	frame_byte_t frame_q[$];      // framed bytes still owed by the DUT
	int          mismatches = 0;
	int          items_sent = 0;
	int unsigned cycle_cnt  = 0;
	bit          idle_on    = 1'b1;  // random idling on both sides
	bit          hold_req   = 1'b0;  // ask the sink for a long hold-off

	// Directed packets. Config is written before the packet once the DUT
	// has drained; pad and packet length are typed where easy to read off.
	pkt_step_t packet_plan [7] = '{
		// reset defaults: block 8, seed 1
		'{1'b0, 32'd0, 1'b0, 32'd0, 16'd1, 16'd1, 1'b0, 32'd0, 8'd10, 32'd12},
		// zero length runs as one byte
		'{1'b0, 32'd0, 1'b0, 32'd0, 16'd0, 16'd1, 1'b0, 32'd0, 8'd10, 32'd12},
		// block 4 with junk above the register width; exact fit gives pad 4
		'{1'b1, 32'hFFFF_FFC4, 1'b0, 32'd0, 16'd3, 16'd3, 1'b0, 32'd0,
			8'd4, 32'd8},
		// block 0 clamps to 4, seed 0 loads 1
		'{1'b1, 32'd0, 1'b1, 32'd0, 16'd1, 16'd1, 1'b0, 32'd0, 8'd6, 32'd8},
		// largest legal block, all-ones seed
		'{1'b1, 32'd32, 1'b1, 32'hFFFF_FFFF, 16'd1, 16'd1, 1'b0, 32'd0,
			8'd26, 32'd28},
		// block 63 clamps to 32; pad 3 grows to 35, the longest tail.
		// A block write inside the packet must not change it.
		'{1'b1, 32'd63, 1'b0, 32'd0, 16'd24, 16'd24, 1'b1, 32'd2,
			8'd35, 32'd60},
		// odd block size, exact fit
		'{1'b1, 32'd7, 1'b1, 32'h9E37_79B9, 16'd2, 16'd2, 1'b0, 32'd0,
			8'd7, 32'd10}
	};

	ssh_binary_packet_framer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH: %s", msg);
	endfunction

	function automatic void push_frame_byte(input logic [7:0] data,
			input ssh_bpf_pkg::kind_t kind, input logic last);
		frame_byte_t fb;
		fb.data = data;
		fb.kind = kind;
		fb.last = last;
		frame_q.insert(frame_q.size(), fb);
	endfunction

	// Frame one accepted payload byte: header on a packet start, the byte
	// itself, and the padding tail once the packet's last byte is in.
	function automatic void frame_payload_byte(input logic [7:0] pay,
			input logic [15:0] len_field);
		int unsigned len;
		int unsigned bs;
		int unsigned pad;
		int unsigned plen;
		logic        lsb;
		if (fr_bytes_left == 16'd0) begin
			len = len_field;
			if (len == 0)
				len = 1;
			if (len > ssh_bpf_pkg::MAX_PAYLOAD)
				len = ssh_bpf_pkg::MAX_PAYLOAD;
			bs = fr_block_size;  // sampled only here, at packet start
			if (bs < ssh_bpf_pkg::BS_MIN)
				bs = ssh_bpf_pkg::BS_MIN;
			if (bs > ssh_bpf_pkg::BS_MAX)
				bs = ssh_bpf_pkg::BS_MAX;
			pad = bs - ((ssh_bpf_pkg::HDR_OVERHEAD + len) % bs);
			if (pad < ssh_bpf_pkg::PAD_MIN)
				pad += bs;
			fr_pad_count  = 6'(pad);
			fr_bytes_left = 16'(len);
			plen          = len + pad + 1;
			fr_last_pad   = pad;
			fr_last_plen  = plen;
			// packet length, big-endian
			push_frame_byte(plen[31:24], ssh_bpf_pkg::KIND_LEN, 1'b0);
			push_frame_byte(plen[23:16], ssh_bpf_pkg::KIND_LEN, 1'b0);
			push_frame_byte(plen[15:8], ssh_bpf_pkg::KIND_LEN, 1'b0);
			push_frame_byte(plen[7:0], ssh_bpf_pkg::KIND_LEN, 1'b0);
			push_frame_byte(8'(pad), ssh_bpf_pkg::KIND_PADLEN, 1'b0);
		end
		push_frame_byte(pay, ssh_bpf_pkg::KIND_PAY, 1'b0);
		fr_bytes_left = fr_bytes_left - 16'd1;
		if (fr_bytes_left == 16'd0) begin
			while (fr_pad_count != 6'd0) begin
				// Galois step, padding byte is the low byte of the new state
				lsb     = fr_lfsr[0];
				fr_lfsr = fr_lfsr >> 1;
				if (lsb)
					fr_lfsr ^= ssh_bpf_pkg::LFSR_TAPS;
				fr_pad_count = fr_pad_count - 6'd1;
				push_frame_byte(fr_lfsr[7:0], ssh_bpf_pkg::KIND_PAD, fr_pad_count == 6'd0);
			end
		end
	endfunction

	// Output side: compare each transfer, then choose next cycle's tready.
	initial begin : frame_sink
		int          hold_left;
		frame_byte_t want;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (m_tvalid && m_tready) begin
					if (frame_q.size() == 0) begin
						note_mismatch($sformatf("unexpected transfer data=%02h kind=%0d last=%0b",
							m_tdata, m_tuser, m_tlast));
					end else begin
						want = frame_q.pop_front();
						if (m_tdata !== want.data || m_tuser !== want.kind ||
								m_tlast !== want.last)
							note_mismatch($sformatf(
								"expected data=%02h kind=%s last=%0b, got data=%02h kind=%0d last=%0b",
								want.data, want.kind.name(), want.last,
								m_tdata, m_tuser, m_tlast));
					end
				end
				if (hold_req) begin
					hold_left = HOLD_CYCLES;
					hold_req  = 1'b0;
				end
				if (hold_left > 0) begin
					hold_left--;
					m_tready <= 1'b0;
				end else begin
					m_tready <= !(idle_on && $urandom_range(99) < 30);
				end
			end
		end
	end

	// Drop tvalid and wait for every queued byte, then let the DUT settle.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (frame_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// cfg_we is lowered again inside the write, so it never drops and rises in one step.
	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == ssh_bpf_pkg::CFG_BLOCK_SIZE)
			fr_block_size = val[5:0];
		else
			fr_lfsr = (val == 32'd0) ? 32'd1 : val;  // zero seed would lock the LFSR
	endtask

	// One input transfer, with random gaps carrying junk data in front.
	task automatic send_payload_byte(input logic [7:0] pay, input logic [15:0] len_field);
		while (idle_on && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 24'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {len_field, pay};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		frame_payload_byte(pay, len_field);
		items_sent++;
	endtask

	// Send n_bytes of one packet. Only the first byte carries the real
	// length; later bytes carry random lengths the DUT must ignore.
	task automatic send_packet(input logic [15:0] len_field, input int n_bytes,
			input logic mid_write, input logic [31:0] mid_bs);
		logic [7:0]  pay;
		logic [15:0] lf;
		for (int i = 0; i < n_bytes; i++) begin
			case ($urandom_range(7))
				0:       pay = 8'h00;
				1:       pay = 8'hFF;
				default: pay = 8'($urandom);
			endcase
			lf = (i == 0) ? len_field : 16'($urandom);
			send_payload_byte(pay, lf);
			if (i == 0 && mid_write) begin
				drain_results();
				write_reg(ssh_bpf_pkg::CFG_BLOCK_SIZE, mid_bs);
			end
		end
	endtask

	initial begin : stimulus
		logic [15:0] len;
		logic [5:0]  bs;
		int          pkt_idx;
		int          r;
		int          start_cnt;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = ssh_bpf_pkg::CFG_BLOCK_SIZE;
		cfg_data      = 32'd0;
		s_tvalid      = 1'b0;
		s_tdata       = 24'd0;
		fr_block_size = BS_RESET;
		fr_lfsr       = SEED_RESET;
		fr_bytes_left = 16'd0;
		fr_pad_count  = 6'd0;
		fr_last_pad   = 0;
		fr_last_plen  = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table
		foreach (packet_plan[k]) begin
			if (packet_plan[k].set_bs || packet_plan[k].set_seed)
				drain_results();
			if (packet_plan[k].set_bs)
				write_reg(ssh_bpf_pkg::CFG_BLOCK_SIZE, packet_plan[k].bs_val);
			if (packet_plan[k].set_seed)
				write_reg(ssh_bpf_pkg::CFG_SEED, packet_plan[k].seed_val);
			send_packet(packet_plan[k].len_field, packet_plan[k].n_bytes,
				packet_plan[k].mid_write, packet_plan[k].mid_bs);
			if (packet_plan[k].exp_pad != 8'd0 &&
					(fr_last_pad != packet_plan[k].exp_pad ||
					fr_last_plen != packet_plan[k].exp_plen))
				note_mismatch($sformatf("row %0d: header pad=%0d plen=%0d, table says %0d/%0d",
					k, fr_last_pad, fr_last_plen, packet_plan[k].exp_pad,
					packet_plan[k].exp_plen));
		end

		// random packets, always completed so the next one starts clean
		pkt_idx   = 0;
		start_cnt = items_sent;
		while (items_sent < start_cnt + RANDOM_ITEMS) begin
			if (pkt_idx != 0 && $urandom_range(3) == 0) begin
				drain_results();
				case ($urandom_range(4))
					0:       bs = 6'd4;
					1:       bs = 6'd32;
					2:       bs = 6'($urandom_range(0, 3));
					3:       bs = 6'($urandom_range(33, 63));
					default: bs = 6'($urandom_range(4, 32));
				endcase
				write_reg(ssh_bpf_pkg::CFG_BLOCK_SIZE, {26'($urandom), bs});
				if ($urandom_range(1) == 0) begin
					case ($urandom_range(3))
						0:       write_reg(ssh_bpf_pkg::CFG_SEED, 32'd0);
						1:       write_reg(ssh_bpf_pkg::CFG_SEED, 32'hFFFF_FFFF);
						2:       write_reg(ssh_bpf_pkg::CFG_SEED, 32'd1);
						default: write_reg(ssh_bpf_pkg::CFG_SEED, $urandom);
					endcase
				end
			end
			r = $urandom_range(99);
			if (r < 10)
				len = 16'd0;
			else if (r < 75)
				len = 16'($urandom_range(1, 12));
			else if (r < 95)
				len = 16'($urandom_range(13, 40));
			else
				len = 16'($urandom_range(41, 120));
			if (pkt_idx == 3) begin
				// sink holds off while the source keeps pushing: the
				// output register fills and s_tready must drop
				drain_results();
				idle_on  = 1'b0;
				hold_req = 1'b1;
				len      = 16'd20;
			end else begin
				// a run of packets with no idling at all
				idle_on = !(pkt_idx >= 6 && pkt_idx < 12);
			end
			send_packet(len, (len == 16'd0) ? 1 : int'(len), 1'b0, 32'd0);
			pkt_idx++;
		end

		// overlong length saturates; the packet is left open at the end
		idle_on = 1'b1;
		send_packet(16'hFFFF, 3, 1'b0, 32'd0);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && frame_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
